### design/imh_pkg.sv
// Shared constants, types and command/status structs for the indexed min-heap.
`timescale 1ns / 1ps
package imh_pkg;

  localparam int unsigned Capacity   = 64;
  localparam int unsigned SlotBits   = 6;   // log2(Capacity)
  localparam int unsigned CountBits  = 7;   // holds Capacity itself
  localparam int unsigned KeyBits    = 32;
  localparam int unsigned VertexBits = 6;
  localparam int unsigned Vertices   = 64;

  localparam logic [1:0] ActInsert  = 2'd0;
  localparam logic [1:0] ActExtract = 2'd1;
  localparam logic [1:0] ActUpdate  = 2'd2;
  localparam logic [1:0] ActUnused  = 2'd3;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StEmpty   = 3'd1;
  localparam logic [2:0] StFull    = 3'd2;
  localparam logic [2:0] StAbsent  = 3'd3;
  localparam logic [2:0] StPresent = 3'd4;

  typedef logic [SlotBits-1:0]   slot_t;
  typedef logic [CountBits-1:0]  count_t;
  typedef logic [KeyBits-1:0]    key_t;
  typedef logic [VertexBits-1:0] vertex_t;

  typedef struct packed {
    vertex_t vtx;
    key_t    key;
  } entry_t;

  // Position map entry: present flag and heap slot
  typedef struct packed {
    logic  pres;
    slot_t slot;
  } map_t;

  // Datapath commands issued by the controller
  typedef enum logic [3:0] {
    CmdNone,
    CmdClear,       // mark one position map entry absent
    CmdLatch,       // capture input word, read map, root and last
    CmdInsStart,    // hold new entry, open hole at slot count, count++
    CmdExStart,     // register root for output, drop its vertex, hold last, count--
    CmdUpdStart,    // hold vertex with new key at its map slot
    CmdUpRead,      // read parent of the hole
    CmdUpMove,      // move parent down into the hole
    CmdDnRead,      // read both children of the hole
    CmdDnMove,      // move best child up into the hole
    CmdFinal,       // write held entry into the hole and set its map entry
    CmdSetStatus    // record status code
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [2:0]  st;
  } ctl_t;

  typedef struct packed {
    logic [1:0] action;
    logic       present;
    logic       full;
    logic       empty;
    logic       has_last;   // more than one entry before extract
    logic       at_root;    // hole sits at slot zero
    logic       up_go;      // parent key strictly greater
    logic       dn_go;      // some child strictly smaller
    logic       clr_last;   // last map entry being cleared
  } sts_t;

endpackage

### design/imh_if.sv
// Valid/ready channel interfaces for input and result words.
`timescale 1ns / 1ps
interface imh_in_if;
  import imh_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  vertex_t    vertex_id;
  key_t       key_value;
  modport source (output valid, action, vertex_id, key_value, input ready);
  modport sink   (input valid, action, vertex_id, key_value, output ready);
endinterface

interface imh_out_if;
  import imh_pkg::*;
  logic       valid;
  logic       ready;
  vertex_t    out_vertex;
  key_t       out_key;
  logic [2:0] status;
  count_t     entry_count;
  logic       heap_empty;
  modport source (output valid, out_vertex, out_key, status, entry_count, heap_empty,
                  input ready);
  modport sink   (input valid, out_vertex, out_key, status, entry_count, heap_empty,
                  output ready);
endinterface

### design/imh_datapath.sv
// Heap storage, position map, sift registers and result register.
`timescale 1ns / 1ps
module imh_datapath
  import imh_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctl_t       ctl_i,
  output sts_t       sts_o,
  input  logic [1:0] action_i,
  input  vertex_t    vertex_i,
  input  key_t       key_i,
  output vertex_t    res_vertex_o,
  output key_t       res_key_o,
  output logic [2:0] res_status_o,
  output count_t     res_count_o
);

  // Heap entries: one write port, two registered read ports
  entry_t heap_q [Capacity];
  // Position map: one write port, one registered read port
  map_t   map_q  [Vertices];

  entry_t     rd_a_q, rd_b_q;
  map_t       map_rd_q;

  logic [1:0] act_q;
  vertex_t    vtx_q;
  key_t       key_q;
  count_t     cnt_q;
  vertex_t    clr_q;
  slot_t      cur_q;
  entry_t     mv_q;
  vertex_t    ovtx_q;
  key_t       okey_q;
  logic [2:0] st_q;

  // Parent and child slots of the hole
  slot_t              par_s;
  logic [CountBits:0] l_w, r_w;
  slot_t              l_s, r_s;
  logic               l_ok, r_ok, take_l, take_r;
  key_t               bestk;
  entry_t             child_e;
  slot_t              child_s;
  count_t             last_w;
  slot_t              last_s;

  // Memory port controls
  logic    rd_en, map_rd_en;
  slot_t   rda, rdb;
  vertex_t map_ra;
  logic    heap_we, map_we;
  slot_t   heap_wa;
  entry_t  heap_wd;
  vertex_t map_wa;
  map_t    map_wd;

  always_comb begin
    par_s   = (cur_q - slot_t'(1)) >> 1;
    l_w     = {1'b0, cur_q, 1'b1};
    r_w     = l_w + (CountBits+1)'(1);
    l_s     = l_w[SlotBits-1:0];
    r_s     = r_w[SlotBits-1:0];
    l_ok    = l_w < {1'b0, cnt_q};
    r_ok    = r_w < {1'b0, cnt_q};
    take_l  = l_ok && (rd_a_q.key < mv_q.key);
    bestk   = take_l ? rd_a_q.key : mv_q.key;
    take_r  = r_ok && (rd_b_q.key < bestk);
    child_e = take_r ? rd_b_q : rd_a_q;
    child_s = take_r ? r_s : l_s;
    last_w  = cnt_q - count_t'(1);
    last_s  = last_w[SlotBits-1:0];
  end

  // Select memory addresses and write data per command
  always_comb begin
    rd_en     = 1'b0;
    map_rd_en = 1'b0;
    rda       = '0;
    rdb       = last_s;
    map_ra    = vertex_i;
    heap_we   = 1'b0;
    heap_wa   = cur_q;
    heap_wd   = mv_q;
    map_we    = 1'b0;
    map_wa    = mv_q.vtx;
    map_wd    = '{pres: 1'b1, slot: cur_q};
    case (ctl_i.cmd)
      CmdClear: begin
        map_we = 1'b1;
        map_wa = clr_q;
        map_wd = '0;
      end
      CmdLatch: begin
        rd_en     = 1'b1;
        map_rd_en = 1'b1;
      end
      CmdExStart: begin
        map_we = 1'b1;
        map_wa = rd_a_q.vtx;
        map_wd = '0;
      end
      CmdUpRead: begin
        rd_en = 1'b1;
        rda   = par_s;
      end
      CmdUpMove: begin
        heap_we = 1'b1;
        heap_wd = rd_a_q;
        map_we  = 1'b1;
        map_wa  = rd_a_q.vtx;
      end
      CmdDnRead: begin
        rd_en = 1'b1;
        rda   = l_s;
        rdb   = r_s;
      end
      CmdDnMove: begin
        heap_we = 1'b1;
        heap_wd = child_e;
        map_we  = 1'b1;
        map_wa  = child_e.vtx;
      end
      CmdFinal: begin
        heap_we = 1'b1;
        map_we  = 1'b1;
      end
      default: ;
    endcase
  end

  // Memories with registered reads
  always_ff @(posedge clk_i) begin
    if (heap_we) heap_q[heap_wa] <= heap_wd;
    if (map_we) map_q[map_wa] <= map_wd;
    if (rd_en) begin
      rd_a_q <= heap_q[rda];
      rd_b_q <= heap_q[rdb];
    end
    if (map_rd_en) map_rd_q <= map_q[map_ra];
  end

  // Entry count and clear pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      clr_q <= '0;
    end else begin
      case (ctl_i.cmd)
        CmdClear:    clr_q <= clr_q + vertex_t'(1);
        CmdInsStart: cnt_q <= cnt_q + count_t'(1);
        CmdExStart:  cnt_q <= cnt_q - count_t'(1);
        default: ;
      endcase
    end
  end

  // Payload, hole and result registers
  always_ff @(posedge clk_i) begin
    case (ctl_i.cmd)
      CmdLatch: begin
        act_q  <= action_i;
        vtx_q  <= vertex_i;
        key_q  <= key_i;
        ovtx_q <= '0;
        okey_q <= '0;
        st_q   <= StOk;
      end
      CmdInsStart: begin
        mv_q  <= '{vtx: vtx_q, key: key_q};
        cur_q <= cnt_q[SlotBits-1:0];
      end
      CmdExStart: begin
        ovtx_q <= rd_a_q.vtx;
        okey_q <= rd_a_q.key;
        mv_q   <= rd_b_q;
        cur_q  <= '0;
      end
      CmdUpdStart: begin
        mv_q  <= '{vtx: vtx_q, key: key_q};
        cur_q <= map_rd_q.slot;
      end
      CmdUpMove: cur_q <= par_s;
      CmdDnMove: cur_q <= child_s;
      CmdSetStatus: begin
        st_q <= ctl_i.st;
        if (ctl_i.st == StEmpty) okey_q <= '1;
      end
      default: ;
    endcase
  end

  always_comb begin
    sts_o.action   = act_q;
    sts_o.present  = map_rd_q.pres;
    sts_o.full     = cnt_q == count_t'(Capacity);
    sts_o.empty    = cnt_q == '0;
    sts_o.has_last = cnt_q > count_t'(1);
    sts_o.at_root  = cur_q == '0;
    sts_o.up_go    = rd_a_q.key > mv_q.key;
    sts_o.dn_go    = take_l || take_r;
    sts_o.clr_last = clr_q == vertex_t'(Vertices - 1);
  end

  assign res_vertex_o = ovtx_q;
  assign res_key_o    = okey_q;
  assign res_status_o = st_q;
  assign res_count_o  = cnt_q;

endmodule

### design/imh_ctrl.sv
// Operation sequencer for insert, extract and update with sift loops.
`timescale 1ns / 1ps
module imh_ctrl
  import imh_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  localparam logic [3:0] SClear  = 4'd0;
  localparam logic [3:0] SIdle   = 4'd1;
  localparam logic [3:0] SDecode = 4'd2;
  localparam logic [3:0] SUpRead = 4'd3;
  localparam logic [3:0] SUpChk  = 4'd4;
  localparam logic [3:0] SDnRead = 4'd5;
  localparam logic [3:0] SDnChk  = 4'd6;
  localparam logic [3:0] SFinal  = 4'd7;
  localparam logic [3:0] SDone   = 4'd8;

  logic [3:0] state_q, state_d;
  logic       upd_q, upd_d;   // update runs a down pass after the up pass
  logic       ovalid_q, ovalid_d;

  assign in_ready_o  = (state_q == SIdle) && !ovalid_q;
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d  = state_q;
    upd_d    = upd_q;
    ovalid_d = ovalid_q;
    ctl_o    = '{cmd: CmdNone, st: StOk};
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    case (state_q)
      SClear: begin
        ctl_o.cmd = CmdClear;
        if (sts_i.clr_last) state_d = SIdle;
      end
      SIdle: begin
        if (in_valid_i && in_ready_o) begin
          ctl_o.cmd = CmdLatch;
          state_d   = SDecode;
        end
      end
      SDecode: begin
        state_d = SDone;
        upd_d   = 1'b0;
        case (sts_i.action)
          ActInsert: begin
            if (sts_i.present) ctl_o = '{cmd: CmdSetStatus, st: StPresent};
            else if (sts_i.full) ctl_o = '{cmd: CmdSetStatus, st: StFull};
            else begin
              ctl_o.cmd = CmdInsStart;
              state_d   = SUpRead;
            end
          end
          ActExtract: begin
            if (sts_i.empty) ctl_o = '{cmd: CmdSetStatus, st: StEmpty};
            else begin
              ctl_o.cmd = CmdExStart;
              state_d   = sts_i.has_last ? SDnRead : SDone;
            end
          end
          ActUpdate: begin
            if (!sts_i.present) ctl_o = '{cmd: CmdSetStatus, st: StAbsent};
            else begin
              ctl_o.cmd = CmdUpdStart;
              upd_d     = 1'b1;
              state_d   = SUpRead;
            end
          end
          default: ;
        endcase
      end
      SUpRead: begin
        if (sts_i.at_root) begin
          state_d = upd_q ? SDnRead : SFinal;
        end else begin
          ctl_o.cmd = CmdUpRead;
          state_d   = SUpChk;
        end
      end
      SUpChk: begin
        if (sts_i.up_go) begin
          ctl_o.cmd = CmdUpMove;
          state_d   = SUpRead;
        end else begin
          state_d = upd_q ? SDnRead : SFinal;
        end
      end
      SDnRead: begin
        ctl_o.cmd = CmdDnRead;
        state_d   = SDnChk;
      end
      SDnChk: begin
        if (sts_i.dn_go) begin
          ctl_o.cmd = CmdDnMove;
          state_d   = SDnRead;
        end else begin
          state_d = SFinal;
        end
      end
      SFinal: begin
        ctl_o.cmd = CmdFinal;
        state_d   = SDone;
      end
      SDone: begin
        ovalid_d = 1'b1;
        state_d  = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SClear;
      upd_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      upd_q    <= upd_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

### design/indexed_min_heap.sv
// Top level of the indexed binary min-heap with decrease/increase key.
//
//  channel | dir | word fields
//  in_ch   | in  | action, vertex_id, key_value
//  out_ch  | out | out_vertex, out_key, status, entry_count, heap_empty
//
// One word at a time. Errors, unused actions and a single-entry extract give a
// valid result without sifting; sifting operations take, per heap level walked,
// a read step and then a compare-and-move step, through registered memory reads.
// After reset a pass clears the position map; input is held off until it ends.
// A result waits in its register until taken; the next word is accepted the cycle after.
`timescale 1ns / 1ps
module indexed_min_heap
  import imh_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  imh_in_if.sink    in_ch,
  imh_out_if.source out_ch
);

  ctl_t ctl;
  sts_t sts;
  count_t cnt;

  imh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  imh_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .action_i     (in_ch.action),
    .vertex_i     (in_ch.vertex_id),
    .key_i        (in_ch.key_value),
    .res_vertex_o (out_ch.out_vertex),
    .res_key_o    (out_ch.out_key),
    .res_status_o (out_ch.status),
    .res_count_o  (cnt)
  );

  assign out_ch.entry_count = cnt;
  assign out_ch.heap_empty  = cnt == '0;

endmodule
